// ----- hdl/frequency_residency_stats_unit_assert.svh -----
// Assertion macros shared by the statistics unit's modules.
`ifndef FREQUENCY_RESIDENCY_STATS_UNIT_ASSERT_SVH
`define FREQUENCY_RESIDENCY_STATS_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/frs_pkg.sv -----
package frs_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);
    localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
    localparam int FREQ_W     = 32;
    localparam int TS_W       = 64;
    localparam int CTR_W      = 32;
    localparam int OP_W       = 3;
    localparam int STAT_W     = 2;

    localparam logic [OP_W-1:0] CMD_LOAD   = 3'd0;
    localparam logic [OP_W-1:0] CMD_START  = 3'd1;
    localparam logic [OP_W-1:0] CMD_CHANGE = 3'd2;
    localparam logic [OP_W-1:0] CMD_SAMPLE = 3'd3;
    localparam logic [OP_W-1:0] CMD_READ   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd1;
    localparam logic [STAT_W-1:0] ST_REJECT  = 2'd2;
    localparam logic [STAT_W-1:0] ST_UNUSED  = 2'd3;

    typedef struct packed {
        logic cap;
        logic wb;
    } t_dp_cmd;

endpackage

// ----- hdl/frs_ctrl.sv -----
module frs_ctrl import frs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_WB
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd.cap   = accept;
    assign o_cmd.wb    = (r_state == S_WB);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`include "frequency_residency_stats_unit_assert.svh"

    `FRS_ASSERT_SAME(a_wb_slot_free, i_clk, i_rst_n, r_state == S_WB, !r_out_valid, "result register occupied during write-back")
    `FRS_ASSERT_NEXT(a_accept_to_wb, i_clk, i_rst_n, accept, r_state == S_WB, "accepted beat not followed by write-back")
    `FRS_ASSERT_NEXT(a_wb_gives_result, i_clk, i_rst_n, r_state == S_WB, r_out_valid, "write-back produced no result")

endmodule

// ----- hdl/frs_dp.sv -----
module frs_dp import frs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [OP_W-1:0]     i_op,
    input  logic [FREQ_W-1:0]   i_freq,
    input  logic [TS_W-1:0]     i_now,
    input  logic [SLOT_W-1:0]   i_from,
    input  logic [SLOT_W-1:0]   i_to,
    output logic [STAT_W-1:0]   o_status,
    output logic [FREQ_W-1:0]   o_read_frequency,
    output logic [TS_W-1:0]     o_read_residency,
    output logic [CTR_W-1:0]    o_read_transitions,
    output logic [CTR_W-1:0]    o_transition_total,
    output logic [SLOT_W-1:0]   o_current_slot,
    output logic                o_current_valid,
    output logic [CNT_W-1:0]    o_slots_used
);

    localparam int MtxDepth = NUM_SLOTS * NUM_SLOTS;
    localparam int MtxAw    = 2 * SLOT_W;

    logic [FREQ_W-1:0] r_freq_mem [NUM_SLOTS];
    logic [TS_W-1:0]   r_res_mem  [NUM_SLOTS];
    logic [CTR_W-1:0]  r_mtx_mem  [MtxDepth];
    logic [NUM_SLOTS-1:0] r_res_vld;
    logic [MtxDepth-1:0]   r_mtx_vld;

    logic [CNT_W-1:0]  r_slots_used, n_slots_used;
    logic [CTR_W-1:0]  r_tcount, n_tcount;
    logic [TS_W-1:0]   r_last_stamp, n_last_stamp;
    logic [SLOT_W-1:0] r_cur_slot, n_cur_slot;
    logic              r_cur_valid, n_cur_valid;

    logic [OP_W-1:0]   r_op;
    logic [FREQ_W-1:0] r_freq;
    logic [TS_W-1:0]   r_now;
    logic [SLOT_W-1:0] r_from;
    logic [SLOT_W-1:0] r_to;
    logic [SLOT_W-1:0] r_idx;
    logic              r_found;
    logic [TS_W-1:0]   r_delta;
    logic [FREQ_W-1:0] r_rd_freq;
    logic [TS_W-1:0]   r_res_q;
    logic [CTR_W-1:0]  r_mtx_q;

    logic [STAT_W-1:0] r_o_status;
    logic [FREQ_W-1:0] r_o_rfreq;
    logic [TS_W-1:0]   r_o_rres;
    logic [CTR_W-1:0]  r_o_rtrans;
    logic [CTR_W-1:0]  r_o_total;
    logic [SLOT_W-1:0] r_o_cur;
    logic              r_o_valid;
    logic [CNT_W-1:0]  r_o_used;

    logic [SLOT_W-1:0] a_idx;
    logic              a_found;
    logic [SLOT_W-1:0] res_raddr;
    logic [MtxAw-1:0]  mtx_raddr;
    logic [MtxAw-1:0]  mtx_waddr;

    logic [STAT_W-1:0] n_status;
    logic [FREQ_W-1:0] n_rfreq;
    logic [TS_W-1:0]   n_rres;
    logic [CTR_W-1:0]  n_rtrans;
    logic              freq_we;
    logic              res_we;
    logic              mtx_we;

    // Lowest used slot holding the incoming frequency.
    always_comb begin
        a_found = 1'b0;
        a_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < r_slots_used) && (r_freq_mem[i] == i_freq)) begin
                a_found = 1'b1;
                a_idx   = SLOT_W'(i);
            end
        end
    end

    assign res_raddr = (i_op == CMD_READ) ? i_from : r_cur_slot;
    assign mtx_raddr = (i_op == CMD_READ) ? {i_from, i_to} : {r_cur_slot, a_idx};
    assign mtx_waddr = {r_cur_slot, r_idx};

    always_comb begin
        n_slots_used = r_slots_used;
        n_tcount     = r_tcount;
        n_last_stamp = r_last_stamp;
        n_cur_slot   = r_cur_slot;
        n_cur_valid  = r_cur_valid;
        n_status     = ST_OK;
        n_rfreq      = '0;
        n_rres       = '0;
        n_rtrans     = '0;
        freq_we      = 1'b0;
        res_we       = 1'b0;
        mtx_we       = 1'b0;
        unique case (r_op)
            CMD_LOAD: begin
                if (r_found || (r_slots_used >= CNT_W'(NUM_SLOTS))) begin
                    n_status = ST_REJECT;
                end else begin
                    freq_we      = 1'b1;
                    n_slots_used = r_slots_used + 1'b1;
                end
            end
            CMD_START: begin
                n_last_stamp = r_now;
                if (r_found) begin
                    n_cur_slot  = r_idx;
                    n_cur_valid = 1'b1;
                end else begin
                    n_cur_slot  = '0;
                    n_cur_valid = 1'b0;
                    n_status    = ST_UNKNOWN;
                end
            end
            CMD_CHANGE: begin
                if (!r_found) begin
                    n_status = ST_UNKNOWN;
                end else if (!r_cur_valid) begin
                    n_last_stamp = r_now;
                    n_cur_slot   = r_idx;
                    n_cur_valid  = 1'b1;
                end else begin
                    res_we       = 1'b1;
                    n_last_stamp = r_now;
                    if (r_idx != r_cur_slot) begin
                        mtx_we     = 1'b1;
                        n_tcount   = r_tcount + 1'b1;
                        n_cur_slot = r_idx;
                    end
                end
            end
            CMD_SAMPLE: begin
                res_we       = r_cur_valid;
                n_last_stamp = r_now;
            end
            CMD_READ: begin
                if (CNT_W'(r_from) >= r_slots_used) begin
                    n_status = ST_UNUSED;
                end else begin
                    n_rfreq = r_rd_freq;
                    n_rres  = r_res_q;
                    if (CNT_W'(r_to) >= r_slots_used) begin
                        n_status = ST_UNUSED;
                    end else begin
                        n_rtrans = r_mtx_q;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op      <= i_op;
            r_freq    <= i_freq;
            r_now     <= i_now;
            r_from    <= i_from;
            r_to      <= i_to;
            r_idx     <= a_idx;
            r_found   <= a_found;
            r_delta   <= i_now - r_last_stamp;
            r_rd_freq <= r_freq_mem[i_from];
            r_res_q   <= r_res_vld[res_raddr] ? r_res_mem[res_raddr] : '0;
            r_mtx_q   <= r_mtx_vld[mtx_raddr] ? r_mtx_mem[mtx_raddr] : '0;
        end
        if (i_cmd.wb && freq_we) begin
            r_freq_mem[r_slots_used[SLOT_W-1:0]] <= r_freq;
        end
        if (i_cmd.wb && res_we) begin
            r_res_mem[r_cur_slot] <= r_res_q + r_delta;
        end
        if (i_cmd.wb && mtx_we) begin
            r_mtx_mem[mtx_waddr] <= r_mtx_q + 1'b1;
        end
        if (i_cmd.wb) begin
            r_o_status  <= n_status;
            r_o_rfreq   <= n_rfreq;
            r_o_rres    <= n_rres;
            r_o_rtrans  <= n_rtrans;
            r_o_total   <= n_tcount;
            r_o_cur     <= n_cur_slot;
            r_o_valid   <= n_cur_valid;
            r_o_used    <= n_slots_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_used <= '0;
            r_tcount     <= '0;
            r_last_stamp <= '0;
            r_cur_slot   <= '0;
            r_cur_valid  <= 1'b0;
            r_res_vld    <= '0;
            r_mtx_vld    <= '0;
        end else if (i_cmd.wb) begin
            r_slots_used <= n_slots_used;
            r_tcount     <= n_tcount;
            r_last_stamp <= n_last_stamp;
            r_cur_slot   <= n_cur_slot;
            r_cur_valid  <= n_cur_valid;
            if (res_we) begin
                r_res_vld[r_cur_slot] <= 1'b1;
            end
            if (mtx_we) begin
                r_mtx_vld[mtx_waddr] <= 1'b1;
            end
        end
    end

    assign o_status           = r_o_status;
    assign o_read_frequency   = r_o_rfreq;
    assign o_read_residency   = r_o_rres;
    assign o_read_transitions = r_o_rtrans;
    assign o_transition_total = r_o_total;
    assign o_current_slot     = r_o_cur;
    assign o_current_valid    = r_o_valid;
    assign o_slots_used       = r_o_used;

`include "frequency_residency_stats_unit_assert.svh"

    `FRS_ASSERT_SAME(a_used_bound, i_clk, i_rst_n, 1'b1, r_slots_used <= CNT_W'(NUM_SLOTS), "slot count beyond table size")
    `FRS_ASSERT_SAME(a_invalid_slot_zero, i_clk, i_rst_n, !r_cur_valid, r_cur_slot == '0, "invalid current slot is not zero")
    `FRS_ASSERT_SAME(a_valid_slot_used, i_clk, i_rst_n, r_cur_valid, CNT_W'(r_cur_slot) < r_slots_used, "current slot lies outside the used slots")

endmodule

// ----- hdl/frequency_residency_stats_unit.sv -----
// Channel   Dir  tdata fields (lowest bit up)                          tuser
// s_axis    in   frequency, time_stamp, from_slot, to_slot (104 bits)   cmd
// m_axis    out  read_frequency, read_residency, read_transitions,     status
//                transition_total, current_slot, current_valid,
//                slots_used (176 bits, top 6 zero)
// Each beat has a lookup and memory read, then a write-back into the result register.
// The residency and transition memories are read in the accept cycle and updated in the next one.
// Synchronous active-low reset clears all counters and the valid bits of both memories at once.
// A held result stalls further input beats until it has been taken.
module frequency_residency_stats_unit import frs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // frequency, time_stamp, from_slot, to_slot
    input  logic [103:0] s_axis_tdata,
    // cmd
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // read_frequency, read_residency, read_transitions, transition_total,
    // current_slot, current_valid, slots_used, zero fill
    output logic [175:0] m_axis_tdata,
    // status
    output logic [1:0]   m_axis_tuser
);

    t_dp_cmd           dp_cmd;
    logic [STAT_W-1:0] status;
    logic [FREQ_W-1:0] read_frequency;
    logic [TS_W-1:0]   read_residency;
    logic [CTR_W-1:0]  read_transitions;
    logic [CTR_W-1:0]  transition_total;
    logic [SLOT_W-1:0] current_slot;
    logic              current_valid;
    logic [CNT_W-1:0]  slots_used;

    frs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (dp_cmd)
    );

    frs_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .i_op               (s_axis_tuser),
        .i_freq             (s_axis_tdata[31:0]),
        .i_now              (s_axis_tdata[95:32]),
        .i_from             (s_axis_tdata[99:96]),
        .i_to               (s_axis_tdata[103:100]),
        .o_status           (status),
        .o_read_frequency   (read_frequency),
        .o_read_residency   (read_residency),
        .o_read_transitions (read_transitions),
        .o_transition_total (transition_total),
        .o_current_slot     (current_slot),
        .o_current_valid    (current_valid),
        .o_slots_used       (slots_used)
    );

    assign m_axis_tuser = status;
    assign m_axis_tdata = {6'd0, slots_used, current_valid, current_slot, transition_total,
                           read_transitions, read_residency, read_frequency};

endmodule
